>>> rtl/assert_macros.svh
// Assertion macros for the RTL file that carries concurrent checks.
// No dependencies; each macro takes a label, a clock and an active-low reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TMBR_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// Next-cycle implication, disabled while reset is asserted.
`define TMBR_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

>>> rtl/tmbr_pkg.sv
// Shared types and constants of the tile map background renderer.
// No dependencies; every other RTL file but tmbr_out_if and the assertion macros imports this package.
package tmbr_pkg;

    localparam int VRAM_BYTES         = 8192;
    localparam int VRAM_AW            = $clog2(VRAM_BYTES);
    localparam int BANK_AW            = VRAM_AW - 1;
    localparam int SCREEN_COLUMNS_DEF = 160;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    localparam logic [1:0] REG_HSCROLL      = 2'd0;
    localparam logic [1:0] REG_VSCROLL      = 2'd1;
    localparam logic [1:0] REG_MAP_SELECT   = 2'd2;
    localparam logic [1:0] REG_SIGNED_TILES = 2'd3;

    localparam logic MODE_WRITE  = 1'b0;
    localparam logic MODE_RENDER = 1'b1;

    // Both tile maps sit above 0x1800; map_select supplies address bit 10.
    localparam logic [1:0]         MAP_BASE_HI = 2'b11;
    localparam logic [VRAM_AW-1:0] SIGNED_BASE = 13'h0800;
    localparam logic [7:0]         TILE_SIGN   = 8'h80;
    localparam logic [2:0]         BIT_MSB     = 3'd7;

    typedef enum logic [0:0] {
        KIND_WRITE  = 1'b0,
        KIND_RENDER = 1'b1
    } t_kind;

    typedef struct packed {
        logic [7:0] hscroll;
        logic [7:0] vscroll;
        logic       map_select;
        logic       signed_tiles;
    } t_cfg;

    typedef struct packed {
        t_kind              kind;
        logic [VRAM_AW-1:0] addr;
        logic [7:0]         data;
        logic [7:0]         line;
        logic [7:0]         column;
        logic [2:0]         row;
        logic [2:0]         fx;
    } t_cmd;

    typedef struct packed {
        logic              valid;
        logic              full;
        logic [QCNT_W-1:0] count;
    } t_q_stat;

endpackage

>>> rtl/tmbr_in_if.sv
// Input item channel: valid/ready handshake with the write and render fields.
// Depends on tmbr_pkg for the address width.
interface tmbr_in_if;
    import tmbr_pkg::*;

    logic               valid;
    logic               ready;
    logic               mode;
    logic [VRAM_AW-1:0] mem_addr;
    logic [7:0]         mem_data;
    logic [7:0]         line;
    logic [7:0]         column;

    modport source (output valid, mode, mem_addr, mem_data, line, column, input ready);
    modport sink   (input valid, mode, mem_addr, mem_data, line, column, output ready);
endinterface

>>> rtl/tmbr_out_if.sv
// Result item channel: valid/ready handshake with the rendered pixel fields.
// No dependencies.
interface tmbr_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] bg_color;
    logic [7:0] pixel_column;
    logic [7:0] pixel_line;

    modport source (output valid, bg_color, pixel_column, pixel_line, input ready);
    modport sink   (input valid, bg_color, pixel_column, pixel_line, output ready);
endinterface

>>> rtl/tmbr_cfg.sv
// APB-style register file for scroll offsets, map select and tile numbering.
// Depends on tmbr_pkg.
module tmbr_cfg (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [tmbr_pkg::APB_AW-1:0]  paddr,
    input  logic [tmbr_pkg::APB_DW-1:0]  pwdata,
    output logic [tmbr_pkg::APB_DW-1:0]  prdata,
    output logic                         pready,
    output tmbr_pkg::t_cfg               o_cfg
);
    import tmbr_pkg::*;

    t_cfg       r_cfg;
    t_cfg       n_cfg;
    logic       w_wr;
    logic [1:0] w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = paddr[3:2];
    assign o_cfg  = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (w_wr) begin
            unique case (w_idx)
                REG_HSCROLL:      n_cfg.hscroll      = pwdata[7:0];
                REG_VSCROLL:      n_cfg.vscroll      = pwdata[7:0];
                REG_MAP_SELECT:   n_cfg.map_select   = pwdata[0];
                REG_SIGNED_TILES: n_cfg.signed_tiles = pwdata[0];
                default:          n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_HSCROLL:      prdata = {24'd0, r_cfg.hscroll};
            REG_VSCROLL:      prdata = {24'd0, r_cfg.vscroll};
            REG_MAP_SELECT:   prdata = {31'd0, r_cfg.map_select};
            REG_SIGNED_TILES: prdata = {31'd0, r_cfg.signed_tiles};
            default:          prdata = '0;
        endcase
    end
endmodule

>>> rtl/tmbr_front.sv
// Front end: accepts items, drops renders past the line end, scrolls and
// forms the tile map address. Depends on tmbr_pkg and tmbr_in_if.
module tmbr_front #(
    parameter int SCREEN_COLUMNS = tmbr_pkg::SCREEN_COLUMNS_DEF
) (
    tmbr_in_if.sink        i_item,
    input  tmbr_pkg::t_cfg i_cfg,
    input  logic           i_q_full,
    output logic           o_push,
    output tmbr_pkg::t_cmd o_cmd
);
    import tmbr_pkg::*;

    localparam logic [8:0] COL_LIMIT = 9'(SCREEN_COLUMNS);

    logic [7:0] w_bg_x;
    logic [7:0] w_bg_y;
    logic       w_in_line;

    assign i_item.ready = !i_q_full;

    assign w_bg_x    = i_item.column + i_cfg.hscroll;
    assign w_bg_y    = i_item.line + i_cfg.vscroll;
    assign w_in_line = {1'b0, i_item.column} < COL_LIMIT;

    always_comb begin
        o_cmd.data   = i_item.mem_data;
        o_cmd.line   = i_item.line;
        o_cmd.column = i_item.column;
        o_cmd.row    = w_bg_y[2:0];
        o_cmd.fx     = w_bg_x[2:0];
        unique case (i_item.mode)
            MODE_RENDER: begin
                o_cmd.kind = KIND_RENDER;
                o_cmd.addr = {MAP_BASE_HI, i_cfg.map_select, w_bg_y[7:3], w_bg_x[7:3]};
                o_push     = i_item.valid && !i_q_full && w_in_line;
            end
            default: begin
                o_cmd.kind = KIND_WRITE;
                o_cmd.addr = i_item.mem_addr;
                o_push     = i_item.valid && !i_q_full;
            end
        endcase
    end
endmodule

>>> rtl/tmbr_queue.sv
// Short command queue that decouples the front end from the memory pipeline.
// Depends on tmbr_pkg.
module tmbr_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  tmbr_pkg::t_cmd    i_cmd,
    input  logic              i_pop,
    output tmbr_pkg::t_cmd    o_cmd,
    output tmbr_pkg::t_q_stat o_stat
);
    import tmbr_pkg::*;

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wp;
    logic [QPTR_W-1:0] r_rp;
    logic [QCNT_W-1:0] r_cnt;

    assign o_cmd        = r_mem[r_rp];
    assign o_stat.count = r_cnt;
    assign o_stat.valid = r_cnt != '0;
    assign o_stat.full  = r_cnt == QCNT_W'(QUEUE_DEPTH);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end
endmodule

>>> rtl/tmbr_back.sv
// Back end: video memory in even and odd byte banks, map read, pattern read
// and bit select in a three-stage pipeline. Depends on tmbr_pkg, tmbr_out_if.
module tmbr_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tmbr_pkg::t_cfg    i_cfg,
    input  tmbr_pkg::t_cmd    i_cmd,
    input  tmbr_pkg::t_q_stat i_q_stat,
    output logic              o_pop,
    tmbr_out_if.source        o_pixel
);
    import tmbr_pkg::*;

    // Pattern rows sit at even addresses, so the low plane byte always comes
    // from the even bank and the high plane byte from the odd bank.
    logic [7:0] r_bank_e [VRAM_BYTES/2];
    logic [7:0] r_bank_o [VRAM_BYTES/2];

    logic       w_en;
    logic       w_wr;
    logic       w_render;

    logic [7:0] r_map_e;
    logic [7:0] r_map_o;
    logic [7:0] r_lo;
    logic [7:0] r_hi;

    logic       r_s1_vld;
    logic       r_s1_odd;
    logic [7:0] r_s1_line;
    logic [7:0] r_s1_col;
    logic [2:0] r_s1_row;
    logic [2:0] r_s1_fx;

    logic       r_s2_vld;
    logic [7:0] r_s2_line;
    logic [7:0] r_s2_col;
    logic [2:0] r_s2_fx;

    logic       r_out_vld;
    logic [1:0] r_out_color;
    logic [7:0] r_out_col;
    logic [7:0] r_out_line;

    logic [7:0]         w_tile;
    logic [VRAM_AW-1:0] w_tile_base;
    logic [BANK_AW-1:0] w_pat_idx;
    logic [2:0]         w_sel;

    // The whole pipeline moves together whenever the output slot is empty or being taken.
    assign w_en     = !r_out_vld || o_pixel.ready;
    assign o_pop    = w_en && i_q_stat.valid;
    assign w_wr     = o_pop && (i_cmd.kind == KIND_WRITE);
    assign w_render = o_pop && (i_cmd.kind == KIND_RENDER);

    assign w_tile = r_s1_odd ? r_map_o : r_map_e;

    always_comb begin
        if (i_cfg.signed_tiles) begin
            w_tile_base = SIGNED_BASE + {1'b0, w_tile ^ TILE_SIGN, 4'b0000};
        end else begin
            w_tile_base = {1'b0, w_tile, 4'b0000};
        end
    end

    assign w_pat_idx = {w_tile_base[VRAM_AW-1:4], r_s1_row};
    assign w_sel     = BIT_MSB - r_s2_fx;

    // A write lands in the cycle it leaves the queue; an older render reading
    // its pattern in that same cycle still sees the previous byte.
    always_ff @(posedge i_clk) begin
        if (w_wr && !i_cmd.addr[0]) begin
            r_bank_e[i_cmd.addr[VRAM_AW-1:1]] <= i_cmd.data;
        end
        if (w_en) begin
            r_map_e <= r_bank_e[i_cmd.addr[VRAM_AW-1:1]];
            r_lo    <= r_bank_e[w_pat_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr && i_cmd.addr[0]) begin
            r_bank_o[i_cmd.addr[VRAM_AW-1:1]] <= i_cmd.data;
        end
        if (w_en) begin
            r_map_o <= r_bank_o[i_cmd.addr[VRAM_AW-1:1]];
            r_hi    <= r_bank_o[w_pat_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_s1_vld  <= w_render;
            r_s2_vld  <= r_s1_vld;
            r_out_vld <= r_s2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_odd    <= i_cmd.addr[0];
            r_s1_line   <= i_cmd.line;
            r_s1_col    <= i_cmd.column;
            r_s1_row    <= i_cmd.row;
            r_s1_fx     <= i_cmd.fx;
            r_s2_line   <= r_s1_line;
            r_s2_col    <= r_s1_col;
            r_s2_fx     <= r_s1_fx;
            r_out_color <= {r_hi[w_sel], r_lo[w_sel]};
            r_out_col   <= r_s2_col;
            r_out_line  <= r_s2_line;
        end
    end

    assign o_pixel.valid        = r_out_vld;
    assign o_pixel.bg_color     = r_out_color;
    assign o_pixel.pixel_column = r_out_col;
    assign o_pixel.pixel_line   = r_out_line;
endmodule

>>> rtl/tile_map_background_renderer.sv
// Tile map background renderer, 2 bits per pixel, one item per cycle sustained unless the output back-pressures.
// A render item's result passes the queue, map read, pattern read and bit select
// registers in order; the map and pattern reads are registered video memory reads.
// Write items update video memory as they leave the queue and produce no result.
// Synchronous active-low reset clears the registers, queue and pipeline
// valids; video memory contents are undefined until written.
`include "assert_macros.svh"

module tile_map_background_renderer #(
    parameter int SCREEN_COLUMNS = tmbr_pkg::SCREEN_COLUMNS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    tmbr_in_if.sink                      i_item,
    tmbr_out_if.source                   o_pixel,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [tmbr_pkg::APB_AW-1:0]  paddr,
    input  logic [tmbr_pkg::APB_DW-1:0]  pwdata,
    output logic [tmbr_pkg::APB_DW-1:0]  prdata,
    output logic                         pready
);
    import tmbr_pkg::*;

    localparam logic [8:0] COL_LIMIT = 9'(SCREEN_COLUMNS);

    t_cfg    w_cfg;
    t_cmd    w_push_cmd;
    t_cmd    w_q_cmd;
    t_q_stat w_q_stat;
    logic    w_push;
    logic    w_pop;
    logic    w_col_over;

    tmbr_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    tmbr_front #(
        .SCREEN_COLUMNS (SCREEN_COLUMNS)
    ) u_front (
        .i_item   (i_item),
        .i_cfg    (w_cfg),
        .i_q_full (w_q_stat.full),
        .o_push   (w_push),
        .o_cmd    (w_push_cmd)
    );

    tmbr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .i_pop   (w_pop),
        .o_cmd   (w_q_cmd),
        .o_stat  (w_q_stat)
    );

    tmbr_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (w_cfg),
        .i_cmd    (w_q_cmd),
        .i_q_stat (w_q_stat),
        .o_pop    (w_pop),
        .o_pixel  (o_pixel)
    );

    assign w_col_over = i_item.mode == MODE_RENDER && !({1'b0, i_item.column} < COL_LIMIT);

    // A render past the line end is accepted but never reaches the queue.
    `TMBR_ASSERT_IMP(a_drop_no_push, i_clk, i_rst_n, i_item.valid && i_item.ready && w_col_over, !w_push)
    // The back end never pops an empty queue.
    `TMBR_ASSERT_IMP(a_pop_nonempty, i_clk, i_rst_n, w_pop, w_q_stat.count != '0)
    // A push into an empty queue is visible to the back end on the next cycle.
    `TMBR_ASSERT_NXT(a_push_visible, i_clk, i_rst_n, w_push && w_q_stat.count == '0, w_q_stat.valid)
endmodule
